// File: hdl/min_tracking_stack_assert.svh
// Assertion macros for the min tracking stack.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on i_clk, off during reset.
`define MTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("min tracking stack: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define MTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("min tracking stack: next-cycle check failed");

`else

`define MTS_ASSERT_NOW(label, ante, cons)
`define MTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hdl/mts_pkg.sv
// Shared types and codes for the min tracking stack.
package mts_pkg;

    // Command codes carried on the input tuser bit
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic push_ok;     // store value, echo it
        logic push_full;   // full status result
        logic pop_empty;   // empty status result
        logic pop_start;   // pop accepted, read data captured this edge
        logic pop_finish;  // form pop result, drop the top level
        logic out_clear;   // output beat taken by the sink
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic out_valid;
    } t_dp_stat;

endpackage

// File: hdl/mts_ctrl.sv
// Controller state machine for the min tracking stack.
module mts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_cmd,
    input  logic             i_m_tready,
    input  mts_pkg::t_dp_stat i_stat,
    output logic             o_s_tready,
    output mts_pkg::t_dp_cmd  o_cmd
);
    import mts_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.pop_start) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs: take a beat only when idle and the output register is empty or being drained
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        w_accept   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = !i_stat.out_valid || i_m_tready;
            end
            ST_POP: begin
                o_cmd.pop_finish = 1'b1;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
        w_accept        = i_s_tvalid && o_s_tready;
        o_cmd.push_ok   = w_accept && (i_cmd == CMD_PUSH) && !i_stat.full;
        o_cmd.push_full = w_accept && (i_cmd == CMD_PUSH) && i_stat.full;
        o_cmd.pop_empty = w_accept && (i_cmd == CMD_POP) && i_stat.empty;
        o_cmd.pop_start = w_accept && (i_cmd == CMD_POP) && !i_stat.empty;
        o_cmd.out_clear = i_stat.out_valid && i_m_tready;
    end

endmodule

// File: hdl/mts_dpath.sv
// Datapath for the min tracking stack: value and minimum stores, count, output register.
module mts_dpath #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mts_pkg::t_dp_cmd              i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_push_value,
    output mts_pkg::t_dp_stat             o_stat,
    output logic signed [DATA_WIDTH-1:0] o_item_value,
    output logic signed [DATA_WIDTH-1:0] o_min_value,
    output logic                         o_min_valid,
    output logic [1:0]                   o_status
);
    import mts_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);
    localparam logic [CW-1:0] COUNT_TWO  = CW'(2);

    // Stores: value at each level and minimum of that level and all below
    logic signed [DATA_WIDTH-1:0] r_val_mem [STACK_DEPTH];
    logic signed [DATA_WIDTH-1:0] r_min_mem [STACK_DEPTH];

    logic [CW-1:0]                r_count;
    logic signed [DATA_WIDTH-1:0] r_top_min;
    logic signed [DATA_WIDTH-1:0] r_rd_val;
    logic signed [DATA_WIDTH-1:0] r_rd_min;
    logic                         r_out_valid;

    logic [CW-1:0]                w_cnt_m1;
    logic [CW-1:0]                w_cnt_m2;
    logic [AW-1:0]                w_wr_addr;
    logic signed [DATA_WIDTH-1:0] w_push_min;

    assign w_cnt_m1  = r_count - COUNT_ONE;
    assign w_cnt_m2  = r_count - COUNT_TWO;
    assign w_wr_addr = r_count[AW-1:0];

    // New running minimum for a push; the empty stack takes the value itself
    assign w_push_min = ((r_count != '0) && (r_top_min < i_push_value)) ?
                        r_top_min : i_push_value;

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == COUNT_FULL);
    assign o_stat.out_valid = r_out_valid;

    // Store writes on push, registered reads of the top and the level below it
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_ok) begin
            r_val_mem[w_wr_addr] <= i_push_value;
            r_min_mem[w_wr_addr] <= w_push_min;
        end
        r_rd_val <= r_val_mem[w_cnt_m1[AW-1:0]];
        r_rd_min <= r_min_mem[w_cnt_m2[AW-1:0]];
    end

    // Level count and top-of-stack minimum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push_ok) begin
            r_count <= r_count + COUNT_ONE;
        end else if (i_cmd.pop_finish) begin
            r_count <= w_cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_ok) begin
            r_top_min <= w_push_min;
        end else if (i_cmd.pop_finish && (r_count > COUNT_ONE)) begin
            r_top_min <= r_rd_min;
        end
    end

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_ok || i_cmd.push_full || i_cmd.pop_empty
                     || i_cmd.pop_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.out_clear) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.push_ok) begin
            o_item_value <= i_push_value;
            o_min_value  <= w_push_min;
            o_min_valid  <= 1'b1;
            o_status     <= STATUS_OK;
        end else if (i_cmd.push_full) begin
            o_item_value <= '0;
            o_min_value  <= r_top_min;
            o_min_valid  <= 1'b1;
            o_status     <= STATUS_FULL;
        end else if (i_cmd.pop_empty) begin
            o_item_value <= '0;
            o_min_value  <= '0;
            o_min_valid  <= 1'b0;
            o_status     <= STATUS_EMPTY;
        end else if (i_cmd.pop_finish) begin
            // a pop that leaves the stack empty reports no minimum
            o_item_value <= r_rd_val;
            o_min_value  <= (r_count > COUNT_ONE) ? r_rd_min : '0;
            o_min_valid  <= (r_count > COUNT_ONE);
            o_status     <= STATUS_OK;
        end else begin
            // no new result: hold the last payload
        end
    end

endmodule

// File: hdl/min_tracking_stack.sv
// Top level of the min tracking stack: controller, datapath and assertions.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | tdata: push_value; tuser: cmd
//  m       | out | o_m_tvalid/i_m_tready  | tdata: item_value, min_value;
//          |     |                        | tuser: min_valid, status
//
// A push or an error beat has its result registered at the accept edge.
// For a pop, the store read port first registers the top entry and the running
// minimum below it, then the result is formed and the count drops.
// Input is taken only while the output register is empty or being drained, so a
// stalled sink holds off the source. Reset (i_rst_n low, synchronous) empties the
// stack and the output register; the stores are not cleared.
module min_tracking_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // push_value [DATA_WIDTH-1:0], zero fill above
    input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]  i_s_tdata,
    // cmd [0]
    input  logic                                     i_s_tuser,
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // item_value [DATA_WIDTH-1:0], min_value [2*DATA_WIDTH-1:DATA_WIDTH], zero fill above
    output logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] o_m_tdata,
    // min_valid [0], status [2:1]
    output logic [2:0]                               o_m_tuser
);
    import mts_pkg::*;

    `include "min_tracking_stack_assert.svh"

    localparam int OW = ((2 * DATA_WIDTH + 7) / 8) * 8;

    t_dp_cmd                      w_cmd;
    t_dp_stat                     w_stat;
    logic signed [DATA_WIDTH-1:0] w_item_value;
    logic signed [DATA_WIDTH-1:0] w_min_value;
    logic                         w_min_valid;
    logic [1:0]                   w_status;
    logic signed [DATA_WIDTH-1:0] w_push_value;

    assign w_push_value = i_s_tdata[DATA_WIDTH-1:0];

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_cmd      (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    mts_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_push_value (w_push_value),
        .o_stat       (w_stat),
        .o_item_value (w_item_value),
        .o_min_value  (w_min_value),
        .o_min_valid  (w_min_valid),
        .o_status     (w_status)
    );

    // Output beat packing
    assign o_m_tvalid = w_stat.out_valid;
    assign o_m_tdata  = OW'({w_min_value, w_item_value});
    assign o_m_tuser  = {w_status, w_min_valid};

    // No input beat while a pop is being finished
    `MTS_ASSERT_NOW(a_busy_pop, w_cmd.pop_finish, !o_s_tready)
    // The output register is empty during the pop read cycle
    `MTS_ASSERT_NEXT(a_pop_gap, w_cmd.pop_start, !o_m_tvalid)
    // An invalid minimum always reads as zero
    `MTS_ASSERT_NOW(a_min_zero, o_m_tvalid && !o_m_tuser[0], w_min_value == '0)
    // A stored push echoes its value with ok status on the next cycle
    `MTS_ASSERT_NEXT(a_push_echo, w_cmd.push_ok, o_m_tvalid && (o_m_tuser[2:1] == STATUS_OK) && (w_item_value == $past(w_push_value)))

endmodule

// File: bench/min_tracking_stack_test.sv
// Self-checking stream testbench for the min tracking stack.
`timescale 1ns / 1ps

module min_tracking_stack_test;
    import mts_pkg::*;

    localparam int DEPTH       = 64;
    localparam int WIDTH       = 32;
    localparam int ITEM_TARGET = 1800;
    localparam int STALL_LIMIT = 2000;

    // one command beat for the stack
    typedef struct {
        logic              cmd;
        logic [WIDTH-1:0]  value;
    } stack_cmd_t;

    // one result beat from the stack
    typedef struct {
        logic [WIDTH-1:0]  item_value;
        logic [WIDTH-1:0]  min_value;
        logic              min_valid;
        logic [1:0]        status;
    } stack_result_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_valid    = 1'b0;
    logic [31:0] s_data     = '0;
    logic        s_user     = CMD_PUSH;
    logic        m_ready    = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [63:0] o_m_tdata;
    logic [2:0]  o_m_tuser;

    stack_cmd_t    cmd_queue[$];
    stack_result_t result_queue[$];

    // shadow stack: value and running minimum per level
    logic signed [WIDTH-1:0] shadow_value[DEPTH];
    logic signed [WIDTH-1:0] shadow_min[DEPTH];
    int                      shadow_count = 0;

    int  gen_count   = 0;
    int  cmd_taken   = 0;
    int  stall_count = 0;
    int  error_count = 0;
    logic calm;

    // quiet stretch with no idling on either side
    assign calm = (cmd_taken >= 800) && (cmd_taken < 1100);

    min_tracking_stack #(
        .STACK_DEPTH(DEPTH),
        .DATA_WIDTH (WIDTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_valid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_data),
        .i_s_tuser (s_user),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_ready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // apply one command to the shadow stack and queue the result it gives
    function automatic void predict_stack(input logic cmd, input logic [WIDTH-1:0] value);
        stack_result_t           res;
        logic signed [WIDTH-1:0] m;
        res = '{item_value: '0, min_value: '0, min_valid: 1'b0, status: STATUS_OK};
        if (cmd == CMD_PUSH) begin
            if (shadow_count >= DEPTH) begin
                res.status    = STATUS_FULL;
                res.min_value = shadow_min[DEPTH-1];
                res.min_valid = 1'b1;
            end else begin
                m = value;
                if (shadow_count > 0 && shadow_min[shadow_count-1] < m)
                    m = shadow_min[shadow_count-1];
                shadow_value[shadow_count] = value;
                shadow_min[shadow_count]   = m;
                shadow_count++;
                res.item_value = value;
                res.min_value  = m;
                res.min_valid  = 1'b1;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                shadow_count--;
                res.item_value = shadow_value[shadow_count];
                if (shadow_count > 0) begin
                    res.min_value = shadow_min[shadow_count-1];
                    res.min_valid = 1'b1;
                end
            end
        end
        result_queue.push_back(res);
    endfunction

    // value mix: extremes, a narrow band so minimums move, and full-range noise
    function automatic logic [WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0;
            3, 4: return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // add a command to the pending list, tracking the depth it leads to
    task automatic add_cmd(input logic cmd, input logic [WIDTH-1:0] value);
        cmd_queue.push_back('{cmd: cmd, value: value});
        if (cmd == CMD_PUSH && gen_count < DEPTH)
            gen_count++;
        else if (cmd == CMD_POP && gen_count > 0)
            gen_count--;
    endtask

    // source side: present beats from the pending list
    always @(posedge i_clk) begin : drive_proc
        stack_cmd_t beat;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready) begin
                predict_stack(s_user, s_data);
                cmd_taken <= cmd_taken + 1;
            end
            if (!s_valid || o_s_tready) begin
                if (cmd_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
                    beat = cmd_queue.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= beat.value;
                    s_user  <= beat.cmd;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink side: random backpressure and result checking
    always @(posedge i_clk) begin : check_proc
        stack_result_t want;
        m_ready <= calm || ($urandom_range(0, 99) >= 11);
        if (i_rst_n && o_m_tvalid && m_ready) begin
            if (result_queue.size() == 0) begin
                $error("unexpected result beat: tdata %h tuser %b", o_m_tdata, o_m_tuser);
                error_count++;
            end else begin
                want = result_queue.pop_front();
                if (o_m_tdata[31:0] !== want.item_value) begin
                    $error("item_value: expected %h, got %h", want.item_value, o_m_tdata[31:0]);
                    error_count++;
                end
                if (o_m_tdata[63:32] !== want.min_value) begin
                    $error("min_value: expected %h, got %h", want.min_value, o_m_tdata[63:32]);
                    error_count++;
                end
                if (o_m_tuser[0] !== want.min_valid) begin
                    $error("min_valid: expected %b, got %b", want.min_valid, o_m_tuser[0]);
                    error_count++;
                end
                if (o_m_tuser[2:1] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tuser[2:1]);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready) || !i_rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int kind;
        int n;
        int push_pct;
        int n_total;

        // directed: empty pop, extremes, pop down to empty, then empty again
        add_cmd(CMD_POP, 32'h1234_5678);
        add_cmd(CMD_PUSH, 32'h0);
        add_cmd(CMD_PUSH, 32'h7fff_ffff);
        add_cmd(CMD_PUSH, 32'h8000_0000);
        add_cmd(CMD_PUSH, 32'hffff_ffff);
        add_cmd(CMD_PUSH, 32'h0000_0001);
        add_cmd(CMD_POP, 32'hffff_ffff);
        add_cmd(CMD_POP, 32'h0);
        add_cmd(CMD_POP, 32'h0);
        add_cmd(CMD_POP, 32'h0);
        add_cmd(CMD_POP, 32'h0);
        add_cmd(CMD_POP, 32'h0);
        add_cmd(CMD_PUSH, 32'h8000_0000);
        add_cmd(CMD_PUSH, 32'h7fff_ffff);
        add_cmd(CMD_PUSH, 32'h5555_5555);
        add_cmd(CMD_PUSH, 32'haaaa_aaaa);
        add_cmd(CMD_POP, 32'h0);
        add_cmd(CMD_POP, 32'h0);
        add_cmd(CMD_POP, 32'h0);
        add_cmd(CMD_POP, 32'h0);

        // random: segments that fill, drain or wander the stack
        while (cmd_queue.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind <= 1) begin
                // fill to full, then push against the limit
                while (gen_count < DEPTH)
                    add_cmd(CMD_PUSH, pick_value());
                n = $urandom_range(1, 3);
                repeat (n) add_cmd(CMD_PUSH, pick_value());
            end else if (kind == 2) begin
                // drain to empty, then pop past the bottom
                while (gen_count > 0)
                    add_cmd(CMD_POP, $urandom);
                n = $urandom_range(1, 2);
                repeat (n) add_cmd(CMD_POP, $urandom);
            end else begin
                push_pct = (kind <= 5) ? 75 : (kind <= 8) ? 30 : 50;
                repeat (20) begin
                    if ($urandom_range(0, 99) < push_pct)
                        add_cmd(CMD_PUSH, pick_value());
                    else
                        add_cmd(CMD_POP, $urandom);
                end
            end
        end
        n_total = cmd_queue.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every command is taken and every result checked
        @(posedge i_clk);
        while (cmd_taken < n_total || result_queue.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (error_count == 0 && result_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/mts_pkg.sv
hdl/mts_ctrl.sv
hdl/mts_dpath.sv
hdl/min_tracking_stack.sv
bench/min_tracking_stack_test.sv
